[src/cgif_pkg.sv]
// Shared types and constants of the 3x3 gray image filter.
`timescale 1ns / 1ps

package cgif_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int ROW_W       = 16;
	localparam int COL_W       = 10;
	localparam int IMG_WIDTH_W = 11;
	localparam int KROW_W      = 24;
	localparam int SHIFT_W     = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int FRAC_BITS   = 8;
	localparam int PROD_W      = 25;
	localparam int SUM_W       = 29;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SAMPLE_W-1:0] LUMA_R = 16'd77;
	localparam logic [SAMPLE_W-1:0] LUMA_G = 16'd150;
	localparam logic [SAMPLE_W-1:0] LUMA_B = 16'd29;

	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_MID    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_SHIFT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE    = 3'd6;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       pixel_out;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             frame_last;
	} result_t;

	typedef struct packed {
		logic             produce;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} item_meta_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] top;
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] bot;
		item_meta_t          meta;
	} queue_entry_t;

endpackage

[src/cgif_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cgif_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/cgif_front.sv]
// Front end: pixel intake, gray conversion, raster counters and line stores.
`timescale 1ns / 1ps

module cgif_front import cgif_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  pixel_t                 pix,
	input  logic [IMG_WIDTH_W-1:0] image_width,
	input  logic [ROW_W-1:0]       image_height,
	input  logic                   color_mode,
	input  logic [LEVEL_W-1:0]     fifo_level,
	output logic                   push,
	output queue_entry_t           push_entry
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int LW = (WW > IMG_WIDTH_W) ? WW : IMG_WIDTH_W;

	logic [CW-1:0]       col_q, col_c, w_last, col_s1;
	logic [ROW_W-1:0]    row_q, h_last;
	logic [LW-1:0]       w_wide, w_eff;
	logic [SAMPLE_W-1:0] sample, sample_s1, rd_a, rd_b;
	logic [LEVEL_W:0]    occupied;
	item_meta_t          meta, meta_s1;
	logic                valid_s1;
	logic                accept;

	always_comb begin
		w_wide = LW'(image_width);
		if (w_wide < LW'(3)) begin
			w_eff = LW'(3);
		end else if (w_wide > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = w_wide;
		end
		w_last = CW'(w_eff - LW'(1));
		h_last = ((image_height < ROW_W'(3)) ? ROW_W'(3) : image_height) - ROW_W'(1);
		col_c  = (col_q >= w_last) ? w_last : col_q;

		if (color_mode) begin
			sample = LUMA_R * SAMPLE_W'(pix.red) + LUMA_G * SAMPLE_W'(pix.green)
				+ LUMA_B * SAMPLE_W'(pix.blue);
		end else begin
			sample = {pix.blue, 8'h00};
		end

		meta.produce = (row_q >= ROW_W'(2)) && (col_c >= CW'(2));
		meta.row     = row_q - ROW_W'(1);
		meta.col     = COL_W'(col_c - CW'(1));
		meta.last    = (row_q >= h_last) && (col_c == w_last);
	end

	assign occupied  = {1'b0, fifo_level} + {{LEVEL_W{1'b0}}, valid_s1};
	assign pix_ready = occupied < (LEVEL_W + 1)'(QUEUE_DEPTH);
	assign accept    = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_c == w_last) begin
					col_q <= '0;
					row_q <= (row_q >= h_last) ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_c + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			col_s1    <= col_c;
			meta_s1   <= meta;
		end
	end

	cgif_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (sample_s1),
		.raddr (col_c),
		.rdata (rd_a)
	);

	cgif_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (rd_a),
		.raddr (col_c),
		.rdata (rd_b)
	);

	assign push            = valid_s1;
	assign push_entry.top  = rd_b;
	assign push_entry.mid  = rd_a;
	assign push_entry.bot  = sample_s1;
	assign push_entry.meta = meta_s1;

`ifndef SYNTH
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && accept |-> col_c != col_s1)
		else $error("line store read and write hit the same column");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> fifo_level < LEVEL_W'(QUEUE_DEPTH))
		else $error("request pushed into a full queue");
`endif

endmodule

[src/cgif_fifo.sv]
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module cgif_fifo import cgif_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  queue_entry_t       push_entry,
	input  logic               pop,
	output queue_entry_t       pop_entry,
	output logic [LEVEL_W-1:0] level
);

	queue_entry_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LEVEL_W-1:0]  level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	assign pop_entry = entry_q[rd_ptr_q];
	assign level     = level_q;

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> level_q != '0)
		else $error("request popped from an empty queue");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> level_q == $past(level_q) + LEVEL_W'(1))
		else $error("queue level lost a request");
`endif

endmodule

[src/cgif_back.sv]
// Back end: 3x3 window, multiply-accumulate, shift and clamp, result register.
`timescale 1ns / 1ps

module cgif_back import cgif_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [2:0][KROW_W-1:0]  kernel,
	input  logic [SHIFT_W-1:0]      result_shift,
	input  logic [LEVEL_W-1:0]      fifo_level,
	input  queue_entry_t            pop_entry,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_ready,
	output result_t                 res
);

	logic [SAMPLE_W-1:0]     win_q [3][3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [SUM_W-1:0]  rsum_s3 [3];
	logic signed [SUM_W-1:0]  total_s4;
	logic signed [SUM_W-1:0]  shifted;
	logic [3:0]               shift_amt;
	logic [7:0]               clamped;
	item_meta_t               meta_s1, meta_s2, meta_s3, meta_s4;
	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic                     res_valid_q;
	result_t                  res_q;
	logic                     en;

	assign en  = !res_valid_q || res_ready;
	assign pop = (fifo_level != '0) && en;

	assign shift_amt = 4'(FRAC_BITS) + {1'b0, result_shift};
	assign shifted   = total_s4 >>> shift_amt;

	always_comb begin
		if (shifted < 0) begin
			clamped = 8'd0;
		end else if (shifted > SUM_W'(255)) begin
			clamped = 8'd255;
		end else begin
			clamped = shifted[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (en) begin
			valid_s1    <= pop && pop_entry.meta.produce;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			res_valid_q <= valid_s4;
			if (pop) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= pop_entry.top;
				win_q[1][2] <= pop_entry.mid;
				win_q[2][2] <= pop_entry.bot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= pop_entry.meta;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= PROD_W'($signed({1'b0, win_q[i][j]}))
						* PROD_W'($signed(kernel[i][8*j +: 8]));
				end
				rsum_s3[i] <= SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1])
					+ SUM_W'(prod_s2[i][2]);
			end
			total_s4 <= rsum_s3[0] + rsum_s3[1] + rsum_s3[2];
			res_q.pixel_out  <= clamped;
			res_q.out_row    <= meta_s4.row;
			res_q.out_col    <= meta_s4.col;
			res_q.frame_last <= meta_s4.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !pop)
		else $error("request taken from queue while result stalled");
`endif

endmodule

[src/conv3x3_gray_image_filter_core.sv]
// Top level of the 3x3 gray image filter: configuration registers and datapath.
`timescale 1ns / 1ps

// Pixels enter in raster order, one request per clock while pix_ready is
// high; each is turned into a Q8.8 gray sample (luma in color mode, blue
// field in gray mode), passed through two line stores and a 3x3 window,
// correlated with the signed 8-bit kernel, shifted right by 8 plus
// result_shift and clamped to 0..255. Only interior pixels give a result,
// tagged with row, column and a frame-end flag; the border is left to the
// consumer. Sustained rate is one pixel per clock while the result side
// keeps up: each line store does one read and one write per pixel. A result
// is offered once its pixel has passed the front register, the queue, the
// back stages s1 to s4 and the result register. The line stores start
// undefined and need no clearing. Write configuration only while the block is
// idle.
module conv3x3_gray_image_filter_core import cgif_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  pixel_t                 pix,
	output logic                   res_valid,
	input  logic                   res_ready,
	output result_t                res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0][KROW_W-1:0]  kernel_q;
	logic [SHIFT_W-1:0]      result_shift_q;
	logic [IMG_WIDTH_W-1:0]  image_width_q;
	logic [ROW_W-1:0]        image_height_q;
	logic                    color_mode_q;

	logic                    push, pop;
	queue_entry_t            push_entry, pop_entry;
	logic [LEVEL_W-1:0]      fifo_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0]    <= 24'h000000;
			kernel_q[1]    <= 24'h010000;
			kernel_q[2]    <= 24'h000000;
			result_shift_q <= '0;
			image_width_q  <= 11'd1024;
			image_height_q <= 16'd768;
			color_mode_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KERNEL_TOP:    kernel_q[0]    <= cfg_data;
				CFG_KERNEL_MID:    kernel_q[1]    <= cfg_data;
				CFG_KERNEL_BOTTOM: kernel_q[2]    <= cfg_data;
				CFG_RESULT_SHIFT:  result_shift_q <= cfg_data[SHIFT_W-1:0];
				CFG_IMAGE_WIDTH:   image_width_q  <= cfg_data[IMG_WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT:  image_height_q <= cfg_data[ROW_W-1:0];
				CFG_COLOR_MODE:    color_mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	cgif_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pix          (pix),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.color_mode   (color_mode_q),
		.fifo_level   (fifo_level),
		.push         (push),
		.push_entry   (push_entry)
	);

	cgif_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.level      (fifo_level)
	);

	cgif_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.kernel       (kernel_q),
		.result_shift (result_shift_q),
		.fifo_level   (fifo_level),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

endmodule
